FILE: hdl/hcbd_pkg.sv
// Shared constants, codes and the hex digit decoder for the chunked body decoder.
`timescale 1ns / 1ps
package hcbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [1:0] STATUS_SATURATED = 2'd3;

    localparam logic [1:0] SKIP_CRLF = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h37);
        end
        return h;
    endfunction

endpackage

FILE: hdl/http_chunked_body_decoder_unit.sv
// Chunked transfer body decoder: raw body words in, decoded payload words out.
//
// Input channel (in_valid/in_ready): one raw body byte per word, end_of_body
// marks the last byte of a body. Output channel (out_valid/out_ready): at most
// one word per input word; is_data flags a payload byte, last flags the final
// word of a body and then status holds ok, empty, truncated or saturated.
// Size lines, chunk trailers and bytes after the terminating zero size give
// no output word unless they carry end_of_body.
// An accepted word is held in the input register and decoded there; its
// result is loaded into the output register when the decode step advances.
// Throughput is one word per cycle while the receiver does not stall, set
// by the single decode step between the two registers.
// When the receiver stalls the output register holds its word; the input
// register keeps taking words that give no result, and a word that does give
// one waits there, which then drops in_ready.
// Reset clears both registers and returns the decoder to the start of a size
// line. After a word with end_of_body the decoder is back in that state.
`timescale 1ns / 1ps
module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_body,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       last,
    output logic [1:0] status
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_REST,
        PH_DATA,
        PH_SKIP,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next;
    logic [SIZE_BITS-1:0]   rem_reg, rem_next;
    logic [1:0]             skip_reg, skip_next;
    logic                   seen_reg, seen_next;
    logic                   ovf_reg, ovf_next;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eob_reg;

    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   is_data_reg;
    logic                   last_reg;
    logic [1:0]             status_reg;

    hcbd_pkg::hex_t         hx;
    logic                   is_ws;
    logic                   is_lf;
    logic                   acc_zero;
    logic                   acc_sat;
    logic [SIZE_BITS-1:0]   acc_digit;
    logic [SIZE_BITS-1:0]   rem_dec;
    logic                   data;
    logic                   trunc;
    logic [1:0]             status_next;
    logic                   produce;
    logic                   advance;

    assign hx        = hcbd_pkg::hex_decode(in_byte_reg);
    assign is_ws     = (in_byte_reg == hcbd_pkg::CHAR_SPACE) ||
                       (in_byte_reg == hcbd_pkg::CHAR_TAB);
    assign is_lf     = (in_byte_reg == hcbd_pkg::CHAR_LF);
    assign acc_zero  = (acc_reg == '0);
    assign acc_sat   = |acc_reg[SIZE_BITS-1 -: 4];
    assign acc_digit = (acc_reg << 4) | SIZE_BITS'(hx.val);
    assign rem_dec   = rem_reg - SIZE_BITS'(1);

    // decode step
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        skip_next  = skip_reg;
        seen_next  = seen_reg;
        ovf_next   = ovf_reg;
        data       = 1'b0;

        case (phase_reg)
            PH_DIGITS, PH_LEAD:
            begin
                if (!(phase_reg == PH_LEAD && is_ws)) begin
                    if (hx.ok) begin
                        phase_next = PH_DIGITS;
                        if (acc_sat) begin
                            acc_next = '1;
                            ovf_next = 1'b1;
                        end
                        else begin
                            acc_next = acc_digit;
                        end
                    end
                    else if (acc_zero) begin
                        phase_next = PH_DONE;
                    end
                    else if (is_lf) begin
                        rem_next   = acc_reg;
                        acc_next   = '0;
                        phase_next = PH_DATA;
                    end
                    else begin
                        phase_next = PH_REST;
                    end
                end
            end
            PH_REST:
            begin
                if (is_lf) begin
                    if (acc_zero) begin
                        phase_next = PH_DONE;
                    end
                    else begin
                        rem_next   = acc_reg;
                        acc_next   = '0;
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                data      = 1'b1;
                seen_next = 1'b1;
                rem_next  = rem_dec;
                if (rem_dec == '0) begin
                    skip_next  = hcbd_pkg::SKIP_CRLF;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (skip_reg != 2'd0) begin
                    skip_next = skip_reg - 2'd1;
                end
                if (skip_reg <= 2'd1) begin
                    phase_next = PH_LEAD;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_LEAD;
            end
        endcase

        trunc = (phase_next == PH_DATA) || (phase_next == PH_REST) ||
                (phase_next == PH_DIGITS && acc_next != '0);
        if (!in_eob_reg) begin
            status_next = hcbd_pkg::STATUS_OK;
        end
        else if (ovf_next) begin
            status_next = hcbd_pkg::STATUS_SATURATED;
        end
        else if (trunc) begin
            status_next = hcbd_pkg::STATUS_TRUNCATED;
        end
        else if (!seen_next) begin
            status_next = hcbd_pkg::STATUS_EMPTY;
        end
        else begin
            status_next = hcbd_pkg::STATUS_OK;
        end

        if (in_eob_reg) begin
            phase_next = PH_LEAD;
            acc_next   = '0;
            rem_next   = '0;
            skip_next  = 2'd0;
            seen_next  = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    assign produce  = data || in_eob_reg;
    assign advance  = in_valid_reg && (!produce || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LEAD;
            acc_reg       <= '0;
            rem_reg       <= '0;
            skip_reg      <= 2'd0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                rem_reg   <= rem_next;
                skip_reg  <= skip_next;
                seen_reg  <= seen_next;
                ovf_reg   <= ovf_next;
            end
            if (advance && produce) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
            in_eob_reg  <= end_of_body;
        end
        if (advance && produce) begin
            out_byte_reg <= data ? in_byte_reg : 8'd0;
            is_data_reg  <= data;
            last_reg     <= in_eob_reg;
            status_reg   <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_data   = is_data_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    a_data_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("data phase with zero bytes remaining");

    a_skip_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != 2'd0)
        else $error("trailer skip with zero count");

    a_eob_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_eob_reg |=> phase_reg == PH_LEAD && !seen_reg && !ovf_reg)
        else $error("decoder not back at size line start after end of body");

    a_status_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != hcbd_pkg::STATUS_OK |-> last_reg)
        else $error("status set on a word without last");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the chunked transfer body decoder.
`timescale 1ns / 1ps
module tb_top;

    localparam int SZ_BITS     = hcbd_pkg::SIZE_BITS_DEFAULT;
    localparam int WORD_TARGET = 1800;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 600;
    localparam int MAX_PRINTS  = 30;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    typedef enum logic [2:0] {
        HDR_LEAD, HDR_DIGITS, HDR_REST, PAYLOAD, TRAILER, MSG_DONE
    } dec_phase_t;

    typedef struct packed {
        logic [7:0] payload;
        logic       data_flag;
        logic       last_flag;
        logic [1:0] status;
    } decoded_word_t;

    class chunked_body_tracker;
        localparam logic [SZ_BITS-1:0] SIZE_ALL_ONES = '1;

        dec_phase_t         ph;
        logic [SZ_BITS-1:0] size_acc;
        logic [SZ_BITS-1:0] remaining;
        logic [1:0]         skip_left;
        bit                 seen_payload;
        bit                 saturated;
        decoded_word_t      expected_words[$];
        int                 mismatches;

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            ph           = HDR_LEAD;
            size_acc     = '0;
            remaining    = '0;
            skip_left    = 2'd0;
            seen_payload = 1'b0;
            saturated    = 1'b0;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function void push_digit(logic [3:0] d);
            if (size_acc > (SIZE_ALL_ONES >> 4))
            begin
                size_acc  = SIZE_ALL_ONES;
                saturated = 1'b1;
            end
            else
            begin
                size_acc = {size_acc[SZ_BITS-5:0], d};
            end
        endfunction

        function void close_number(bit at_lf);
            if (size_acc == '0)
                ph = MSG_DONE;
            else if (at_lf)
            begin
                remaining = size_acc;
                size_acc  = '0;
                ph        = PAYLOAD;
            end
            else
                ph = HDR_REST;
        endfunction

        function void note_raw_word(logic [7:0] b, logic eob);
            decoded_word_t w;
            int            h;
            bit            data;
            bit            trunc;
            data = 1'b0;
            h    = hex_digit(b);
            case (ph)
                HDR_LEAD:
                begin
                    if (b != hcbd_pkg::CHAR_SPACE && b != hcbd_pkg::CHAR_TAB)
                    begin
                        if (h >= 0)
                        begin
                            push_digit(h[3:0]);
                            ph = HDR_DIGITS;
                        end
                        else
                            close_number(b == hcbd_pkg::CHAR_LF);
                    end
                end
                HDR_DIGITS:
                begin
                    if (h >= 0)
                        push_digit(h[3:0]);
                    else
                        close_number(b == hcbd_pkg::CHAR_LF);
                end
                HDR_REST:
                begin
                    if (b == hcbd_pkg::CHAR_LF)
                        close_number(1'b1);
                end
                PAYLOAD:
                begin
                    data         = 1'b1;
                    seen_payload = 1'b1;
                    remaining    = remaining - 1'b1;
                    if (remaining == '0)
                    begin
                        skip_left = hcbd_pkg::SKIP_CRLF;
                        ph        = TRAILER;
                    end
                end
                TRAILER:
                begin
                    if (skip_left > 2'd0)
                        skip_left = skip_left - 2'd1;
                    if (skip_left == 2'd0)
                        ph = HDR_LEAD;
                end
                default: ;
            endcase
            if (!data && !eob)
                return;
            w.payload   = data ? b : 8'h00;
            w.data_flag = data;
            w.last_flag = eob;
            w.status    = hcbd_pkg::STATUS_OK;
            if (eob)
            begin
                trunc = (ph == PAYLOAD) || (ph == HDR_REST) ||
                        (ph == HDR_DIGITS && size_acc != '0);
                if (saturated)
                    w.status = hcbd_pkg::STATUS_SATURATED;
                else if (trunc)
                    w.status = hcbd_pkg::STATUS_TRUNCATED;
                else if (!seen_payload)
                    w.status = hcbd_pkg::STATUS_EMPTY;
                clear_state();
            end
            expected_words.push_back(w);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_decoded_word(logic [7:0] ob, logic d, logic l, logic [1:0] s);
            decoded_word_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word byte=%0h data=%0b last=%0b st=%0d",
                                          ob, d, l, s));
                return;
            end
            want = expected_words.pop_front();
            if (d !== want.data_flag)
                report_mismatch($sformatf("is_data %0b, want %0b", d, want.data_flag));
            if (ob !== want.payload)
                report_mismatch($sformatf("out_byte %0h, want %0h", ob, want.payload));
            if (l !== want.last_flag)
                report_mismatch($sformatf("last %0b, want %0b", l, want.last_flag));
            if (s !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", s, want.status));
        endtask

        task check_drained();
            if (expected_words.size() != 0)
                report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
        endtask

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       end_of_body;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
    logic [1:0] status;

    chunked_body_tracker tracker;
    logic [7:0]          raw_body[$];
    int                  words_sent;
    int                  idle_cycles;
    bit                  steady_send;

    http_chunked_body_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_body (end_of_body),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_data     (is_data),
        .last        (last),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && tracker != null)
        begin
            if (in_valid && in_ready)
                tracker.note_raw_word(in_byte, end_of_body);
            if (out_valid && out_ready)
                tracker.check_decoded_word(out_byte, is_data, last, status);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("http_chunked_body_decoder_unit regression: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        int  r;
        int  n;
        bit  held;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && words_sent >= HOLD_AT)
            begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_ready = 1'b1;
                    n = $urandom_range(1, 20);
                end
                else if (r < 85)
                begin
                    out_ready = 1'b0;
                    n = $urandom_range(1, 3);
                end
                else if (r < 95)
                begin
                    out_ready = 1'b0;
                    n = $urandom_range(4, 12);
                end
                else if (r < 98)
                begin
                    out_ready = 1'b0;
                    n = $urandom_range(20, 60);
                end
                else
                begin
                    out_ready = 1'b1;
                    n = $urandom_range(100, 200);
                end
                repeat (n) @(negedge clk);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int r;
        if (steady_send)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10)
            return CHAR_ZERO + nib;
        return ($urandom_range(0, 1) ? "A" : "a") + (nib - 4'd10);
    endfunction

    function automatic logic [7:0] non_lf_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == hcbd_pkg::CHAR_LF);
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [7:0] b, input logic eob);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        in_byte     = b;
        end_of_body = eob;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_body();
        int i;
        for (i = 0; i < raw_body.size(); i++)
            send_word(raw_body[i], i == raw_body.size() - 1);
    endtask

    task automatic push_size_line(input int unsigned n);
        int         k;
        bit         started;
        logic [3:0] nib;
        started = 1'b0;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                raw_body.push_back($urandom_range(0, 1) ? hcbd_pkg::CHAR_SPACE
                                                        : hcbd_pkg::CHAR_TAB);
        if ($urandom_range(0, 7) == 0)
            raw_body.push_back(CHAR_ZERO);
        for (k = 7; k >= 0; k--)
        begin
            nib = n[4*k +: 4];
            if (nib != 4'd0 || started || k == 0)
            begin
                started = 1'b1;
                raw_body.push_back(hex_char(nib));
            end
        end
        if ($urandom_range(0, 5) == 0)
        begin
            raw_body.push_back(CHAR_SEMI);
            repeat ($urandom_range(0, 4)) raw_body.push_back(non_lf_byte());
        end
        if ($urandom_range(0, 9) != 0)
            raw_body.push_back(CHAR_CR);
        raw_body.push_back(hcbd_pkg::CHAR_LF);
    endtask

    task automatic build_message();
        int          r;
        int          nch;
        int unsigned len;
        raw_body.delete();
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 12)) raw_body.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 12)
        begin
            // oversized chunk: the size saturates and the body is cut short
            raw_body.push_back(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(8, 9))
                raw_body.push_back(hex_char(4'($urandom_range(0, 15))));
            raw_body.push_back(CHAR_CR);
            raw_body.push_back(hcbd_pkg::CHAR_LF);
            repeat ($urandom_range(0, 4)) raw_body.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            nch = $urandom_range(0, 4);
            repeat (nch)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 8);
                push_size_line(len);
                repeat (len) raw_body.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                    repeat (2) raw_body.push_back(8'($urandom_range(0, 255)));
                else
                begin
                    raw_body.push_back(CHAR_CR);
                    raw_body.push_back(hcbd_pkg::CHAR_LF);
                end
            end
            if ($urandom_range(0, 5) == 0)
            begin
                raw_body.push_back(CHAR_CR);
                raw_body.push_back(hcbd_pkg::CHAR_LF);
            end
            else
                push_size_line(0);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 5)) raw_body.push_back(8'($urandom_range(0, 255)));
            else
            begin
                raw_body.push_back(CHAR_CR);
                raw_body.push_back(hcbd_pkg::CHAR_LF);
            end
            if ($urandom_range(0, 6) == 0 && raw_body.size() > 1)
                raw_body = raw_body[0:$urandom_range(0, raw_body.size() - 2)];
        end
    endtask

    initial
    begin
        int msg_count;
        tracker     = new();
        words_sent  = 0;
        idle_cycles = 0;
        steady_send = 1'b0;
        msg_count   = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        end_of_body = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // blanks, LF straight after the size, one 0xFF data byte, CR LF, zero size
        raw_body = '{hcbd_pkg::CHAR_SPACE, hcbd_pkg::CHAR_TAB, "1", hcbd_pkg::CHAR_LF,
                     8'hFF, CHAR_CR, hcbd_pkg::CHAR_LF, "0"};
        send_body();
        // line with no digits, then bytes after the end of message
        raw_body = '{CHAR_CR, 8'h00, 8'h80};
        send_body();
        // nine hex digits: saturated size
        raw_body = '{"f", "F", "F", "F", "F", "F", "F", "F", "F"};
        send_body();
        // body ends in the rest of a size line
        raw_body = '{"2", CHAR_SEMI};
        send_body();
        // end marker on a data word
        raw_body = '{"1", hcbd_pkg::CHAR_LF, "Z"};
        send_body();

        while (words_sent < WORD_TARGET)
        begin
            steady_send = (msg_count % 12 == 5);
            build_message();
            send_body();
            msg_count++;
        end
        in_valid    = 1'b0;
        end_of_body = 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        tracker.check_drained();
        if (tracker.mismatches == 0)
            $display("http_chunked_body_decoder_unit regression: pass");
        else
            $display("http_chunked_body_decoder_unit regression: fail");
        $finish;
    end

endmodule

FILE: http_chunked_body_decoder_unit.f
hdl/hcbd_pkg.sv
hdl/http_chunked_body_decoder_unit.sv
sim/tb_top.sv
